FILE: sv/sdsh_pkg.sv
// Package: shared constants and result type for the SD SPI host engine.
`default_nettype none
package sdsh_pkg;
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] mosi;
        logic       cs;
        logic [7:0] rd;
        logic       st;
    } t_res;
    localparam logic [1:0] K_XCHG = 2'd0;
    localparam logic [1:0] K_READ = 2'd1;
    localparam logic [1:0] K_NEED = 2'd2;
    localparam logic [1:0] K_DONE = 2'd3;
    localparam logic [2:0] A_INIT  = 3'd0;
    localparam logic [2:0] A_READ  = 3'd1;
    localparam logic [2:0] A_WRITE = 3'd2;
    localparam logic [2:0] A_CARD  = 3'd3;
    localparam logic [2:0] A_WDATA = 3'd4;
    localparam logic [2:0] REG_READY = 3'd0;
    localparam logic [2:0] REG_TOKEN = 3'd1;
    localparam logic [2:0] REG_BUSY  = 3'd2;
    localparam logic [2:0] REG_RETRY = 3'd3;
    localparam logic [2:0] REG_RESP  = 3'd4;
endpackage
`default_nettype wire

FILE: sv/sdsh_out_buf.sv
// Output buffer: holds up to two result items of one input and a spare slot pair.
`default_nettype none
module sdsh_out_buf import sdsh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [1:0]  i_cnt,
    input  wire logic [24:0] i_r0,
    input  wire logic [24:0] i_r1,
    output logic             o_room,
    output logic             o_valid,
    output logic [24:0]      o_data,
    input  wire logic        i_ready
);
    // four-entry ring of 25-bit packed items
    logic [24:0] r_mem [4];
    logic [1:0]  r_rd, r_wr;
    logic [2:0]  r_cnt;
    logic        pop;
    assign pop     = o_valid && i_ready;
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_mem[r_rd];
    assign o_room  = r_cnt <= 3'd2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            if (i_push && i_cnt != 2'd0) begin
                r_mem[r_wr] <= i_r0;
                if (i_cnt == 2'd2) r_mem[r_wr + 2'd1] <= i_r1;
                r_wr <= r_wr + i_cnt;
            end
            if (pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + ((i_push) ? {1'b0, i_cnt} : 3'd0) - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

FILE: sv/sd_spi_host_engine_unit.sv
// Top level: SD card SPI mode host sequencer with stream ports and APB registers.
// Results are written to the output buffer at the accepting edge and are read out from its ring registers.
// Throughput: one item per cycle while the four-entry output buffer has room for two.
// Each item yields at most two results; the step logic is combinational.
// Reset: synchronous active low; idle, no card, slow clock, registers at defaults.
`default_nettype none
module sd_spi_host_engine_unit import sdsh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: block_address[31:0], block_count[63:32], miso_byte[71:64], write_data[79:72]
    input  wire logic [79:0] s_axis_tdata,
    // tuser: action[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: mosi_byte[7:0], select_low[8], fast_clock[9], read_byte[17:10], status[18],
    // card_kind[21:19], zero[23:22]
    output logic [23:0]      m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam logic [4:0] P_IDLE=5'd0, I_WAKE=5'd1, I_CMD0=5'd2, I_CMD8=5'd3, I_OCR8=5'd4,
        I_A41V2=5'd5, I_CMD58=5'd6, I_OCR58=5'd7, I_A41PROBE=5'd8, I_V1LOOP=5'd9,
        I_CMD16=5'd10, I_FINAL=5'd11, R_CMD=5'd12, R_TOKEN=5'd13, R_DATA=5'd14,
        R_CRC=5'd15, W_CMD=5'd16, W_TOKEN=5'd17, W_NEED=5'd18, W_DATA=5'd19,
        W_CRC=5'd20, W_RESP=5'd21, W_BUSY=5'd22, X_DESEL=5'd23, X_FAIL=5'd24;
    localparam logic [2:0] C_NONE=3'd0, C_DESEL=3'd1, C_SEL=3'd2, C_READY=3'd3,
        C_FRAME=3'd4, C_RESP=3'd5;

    logic [19:0] r_lim_ready, r_lim_token, r_lim_busy;
    logic [15:0] r_lim_retry;
    logic [3:0]  r_lim_resp;
    logic [4:0]  r_phase, n_phase;
    logic [2:0]  r_ctype, n_ctype, r_cstage, n_cstage;
    logic        r_rdy, n_rdy, r_slow, n_slow, r_apppend, n_apppend, r_opw, n_opw;
    logic [31:0] r_addr, n_addr, r_left, n_left, r_ocr, n_ocr, r_apparg, n_apparg;
    logic [9:0]  r_bi, n_bi;
    logic [19:0] r_poll, n_poll;
    logic [15:0] r_retry, n_retry;
    logic [47:0] r_frame, n_frame;
    logic [5:0]  r_appidx, n_appidx;
    logic [2:0]  r_ptype, n_ptype;

    t_res        res0, res1;
    logic [1:0]  cnt;
    logic [2:0]  ct_out0, ct_out1;
    logic        fast0, fast1;
    logic        room, acc;

    assign pready = 1'b1;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_ready <= 20'd50000; r_lim_token <= 20'd40000; r_lim_busy <= 20'd500000;
            r_lim_retry <= 16'd10000; r_lim_resp <= 4'd10;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_READY: r_lim_ready <= pwdata[19:0];
                REG_TOKEN: r_lim_token <= pwdata[19:0];
                REG_BUSY:  r_lim_busy  <= pwdata[19:0];
                REG_RETRY: r_lim_retry <= pwdata[15:0];
                REG_RESP:  r_lim_resp  <= pwdata[3:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[4:2])
            REG_READY: prdata = {12'd0, r_lim_ready};
            REG_TOKEN: prdata = {12'd0, r_lim_token};
            REG_BUSY:  prdata = {12'd0, r_lim_busy};
            REG_RETRY: prdata = {16'd0, r_lim_retry};
            REG_RESP:  prdata = {28'd0, r_lim_resp};
            default:   prdata = '0;
        endcase
    end

    function automatic logic [47:0] mkframe(input logic [5:0] idx, input logic [31:0] arg);
        logic [7:0] crc;
        crc = (idx == 6'd0) ? 8'h95 : (idx == 6'd8) ? 8'h87 : 8'h01;
        return {2'b01, idx, arg, crc};
    endfunction

    always_comb begin
        logic [2:0]  act;
        logic [7:0]  rx;
        logic        emitx, cmdi, dodisp, ready_chk, cmd_done, loop, nb, fail, fin, fininit;
        logic        bok, tokc, busyc;
        logic [7:0]  r;
        logic [2:0]  finty;
        logic        finst;
        logic [5:0]  sidx;
        logic        sapp, scmd;
        logic [31:0] sarg;
        logic [3:0]  lim;
        logic [2:0]  bsel;
        act = s_axis_tuser; rx = s_axis_tdata[71:64];
        n_phase=r_phase; n_ctype=r_ctype; n_cstage=r_cstage; n_rdy=r_rdy; n_slow=r_slow;
        n_apppend=r_apppend; n_opw=r_opw; n_addr=r_addr; n_left=r_left; n_ocr=r_ocr;
        n_apparg=r_apparg; n_bi=r_bi; n_poll=r_poll; n_retry=r_retry; n_frame=r_frame;
        n_appidx=r_appidx; n_ptype=r_ptype;
        res0='0; res1='0; cnt=2'd0; ct_out0=r_ctype; ct_out1=r_ctype; fast0=!r_slow; fast1=!r_slow;
        cmdi=0; dodisp=0; ready_chk=0; cmd_done=0; loop=0; nb=0; fail=0; fin=0; fininit=0;
        bok=0; tokc=0; busyc=0; r=8'hFF; finty=3'd0; finst=0; sidx='0; sapp=0; scmd=0;
        sarg='0; lim='0; emitx=0; bsel='0;
        // each branch emits up to two results, some via flags resolved below
        if (act <= A_WRITE) begin
            if (r_phase == P_IDLE) begin
                if (act == A_INIT) begin
                    n_slow=1; fast0=0; n_apppend=0; n_cstage=C_NONE; n_phase=I_WAKE; n_bi='0;
                    res0='{K_XCHG,8'hFF,1'b0,8'h00,1'b0}; cnt=2'd1;
                end else if (!r_rdy) begin
                    fin=1; finst=1;
                end else begin
                    n_opw = (act == A_WRITE);
                    n_addr = (r_ctype != 3'd4) ? {s_axis_tdata[22:0], 9'd0} : s_axis_tdata[31:0];
                    n_left = s_axis_tdata[63:32];
                    nb=1;
                end
            end
        end else if (act == A_CARD) begin
            if (r_phase != P_IDLE && r_phase != W_NEED) begin
                if (r_cstage != C_NONE) begin
                    unique case (r_cstage)
                        C_DESEL: begin n_cstage=C_SEL; cmdi=1; end
                        C_SEL: begin
                            if (r_slow) begin n_cstage=C_FRAME; n_bi='0; cmdi=1; end
                            else begin n_poll='0; ready_chk=1; end
                        end
                        C_READY: begin
                            if (rx == 8'hFF) begin n_cstage=C_FRAME; n_bi='0; cmdi=1; end
                            else begin n_poll=r_poll+20'd1; ready_chk=1; end
                        end
                        C_FRAME: begin
                            n_bi=r_bi+10'd1;
                            if (n_bi >= 10'd6) begin n_cstage=C_RESP; n_poll='0; end
                            cmdi=1;
                        end
                        default: begin
                            n_poll=r_poll+20'd1;
                            lim = (r_lim_resp != 4'd0) ? r_lim_resp : 4'd1;
                            if (rx[7] && n_poll < {16'd0, lim}) cmdi=1;
                            else begin cmd_done=1; r=rx; end
                        end
                    endcase
                    if (ready_chk) begin
                        if (n_poll >= r_lim_ready) begin cmd_done=1; r=8'hFF; end
                        else begin n_cstage=C_READY; cmdi=1; end
                    end
                    if (cmd_done) begin
                        n_cstage=C_NONE;
                        if (r_apppend) begin
                            n_apppend=0;
                            if (r > 8'd1) dodisp=1;
                            else begin
                                n_frame=mkframe(r_appidx, r_apparg); n_cstage=C_DESEL; cmdi=1;
                            end
                        end else dodisp=1;
                    end
                end else begin
                    case (r_phase)
                        I_WAKE: begin
                            n_bi=r_bi+10'd1;
                            if (n_bi < 10'd10) res0='{K_XCHG,8'hFF,1'b0,8'h00,1'b0};
                            else begin n_phase=I_CMD0; scmd=1; sidx=6'd0; end
                            cnt = (n_bi < 10'd10) ? 2'd1 : 2'd0;
                        end
                        I_OCR8, I_OCR58: begin
                            n_ocr={r_ocr[23:0], rx}; n_bi=r_bi+10'd1;
                            if (n_bi < 10'd4) begin
                                res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd1;
                            end else if (r_phase == I_OCR58) begin
                                fininit=1; finty = n_ocr[30] ? 3'd4 : 3'd3;
                            end else if (n_ocr[15:0] == 16'h01AA) begin
                                n_retry=r_lim_retry; n_phase=I_A41V2; loop=1;
                            end else fininit=1;
                        end
                        I_FINAL: begin
                            if (r_ctype != 3'd0) begin n_slow=0; n_rdy=1; end else n_rdy=0;
                            fast0 = !n_slow; fin=1; finst = (r_ctype == 3'd0);
                        end
                        R_TOKEN: begin
                            if (rx != 8'hFF) begin
                                if (rx == 8'hFE) begin
                                    n_phase=R_DATA; n_bi='0;
                                    res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd1;
                                end else fail=1;
                            end else begin n_poll=r_poll+20'd1; tokc=1; end
                        end
                        R_DATA: begin
                            res0='{K_READ,8'h00,1'b0,rx,1'b0};
                            res1='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd2;
                            n_bi=r_bi+10'd1;
                            if (r_bi == 10'd511) begin n_phase=R_CRC; n_bi='0; end
                        end
                        R_CRC: begin
                            n_bi=r_bi+10'd1;
                            if (n_bi < 10'd2) begin
                                res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd1;
                            end else bok=1;
                        end
                        W_TOKEN: begin
                            n_bi='0; n_phase=W_NEED; res0='{K_NEED,8'h00,1'b0,8'h00,1'b0}; cnt=2'd1;
                        end
                        W_DATA: begin
                            n_bi=r_bi+10'd1;
                            if (r_bi != 10'd511) begin
                                n_phase=W_NEED; res0='{K_NEED,8'h00,1'b0,8'h00,1'b0};
                            end else begin
                                n_phase=W_CRC; n_bi='0; res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0};
                            end
                            cnt=2'd1;
                        end
                        W_CRC: begin
                            n_bi=r_bi+10'd1;
                            if (n_bi >= 10'd2) n_phase=W_RESP;
                            res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd1;
                        end
                        W_RESP: begin
                            if (rx[4:0] != 5'h05) fail=1;
                            else begin n_phase=W_BUSY; n_poll='0; busyc=1; end
                        end
                        W_BUSY: begin
                            if (rx != 8'h00) bok=1; else begin n_poll=r_poll+20'd1; busyc=1; end
                        end
                        X_DESEL: begin
                            n_addr = r_addr + ((r_ctype == 3'd4) ? 32'd1 : 32'd512);
                            n_left = r_left - 32'd1; nb=1;
                        end
                        X_FAIL: begin fin=1; finst=1; end
                        default: dodisp=1;
                    endcase
                end
            end
        end else if (act == A_WDATA) begin
            if (r_phase == W_NEED) begin
                n_phase=W_DATA; res0='{K_XCHG,s_axis_tdata[79:72],1'b1,8'h00,1'b0}; cnt=2'd1;
            end
        end
        if (dodisp) begin
            unique case (r_phase)
                I_CMD0: if (r == 8'd1) begin n_phase=I_CMD8; scmd=1; sidx=6'd8;
                            sarg=32'h1AA; end else fininit=1;
                I_CMD8: if (r == 8'd1) begin n_phase=I_OCR8; n_bi='0; emitx=1; end
                        else begin n_phase=I_A41PROBE; scmd=1; sapp=1; sidx=6'd41; end
                I_A41V2: if (r == 8'd0) begin n_phase=I_CMD58; scmd=1; sidx=6'd58; end
                         else begin n_retry=r_retry-16'd1; loop=1; end
                I_CMD58: if (r == 8'd0) begin n_phase=I_OCR58; n_bi='0; emitx=1; end
                         else fininit=1;
                I_A41PROBE: begin
                    n_ptype = (r <= 8'd1) ? 3'd2 : 3'd1; n_retry=r_lim_retry;
                    n_phase=I_V1LOOP; loop=1;
                end
                I_V1LOOP: if (r == 8'd0) begin n_phase=I_CMD16; scmd=1; sidx=6'd16;
                              sarg=32'd512; end
                          else begin n_retry=r_retry-16'd1; loop=1; end
                I_CMD16: begin fininit=1; finty = (r == 8'd0) ? r_ptype : 3'd0; end
                R_CMD: if (r != 8'd0) fail=1;
                       else begin n_phase=R_TOKEN; n_poll='0; tokc=1; end
                W_CMD: if (r != 8'd0) fail=1;
                       else begin n_phase=W_TOKEN; res0='{K_XCHG,8'hFE,1'b1,8'h00,1'b0};
                           cnt=2'd1; end
                default: fail=1;
            endcase
        end
        if (emitx) begin res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd1; end
        if (tokc) begin
            if (n_poll >= r_lim_token) fail=1;
            else begin res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd1; end
        end
        if (busyc) begin
            if (n_poll >= r_lim_busy) fail=1;
            else begin res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0}; cnt=2'd1; end
        end
        if (loop) begin
            if (n_retry == 16'd0) fininit=1;
            else if (r_phase == I_A41V2 && n_phase == I_A41V2 || n_phase == I_A41V2) begin
                scmd=1; sapp=1; sidx=6'd41; sarg=32'h4000_0000;
            end else if (n_ptype == 3'd2) begin scmd=1; sapp=1; sidx=6'd41; end
            else begin scmd=1; sidx=6'd1; end
        end
        if (nb) begin
            if (n_left == 32'd0) begin fin=1; finst=0; end
            else begin
                n_phase = n_opw ? W_CMD : R_CMD; scmd=1;
                sidx = n_opw ? 6'd24 : 6'd17; sarg=n_addr;
            end
        end
        if (scmd) begin
            n_apppend=sapp;
            if (sapp) begin n_appidx=sidx; n_apparg=sarg; n_frame=mkframe(6'd55, 32'd0); end
            else n_frame=mkframe(sidx, sarg);
            n_cstage=C_DESEL; cmdi=1;
        end
        if (cmdi) begin
            bsel = (n_bi[2:0] >= 3'd6) ? n_bi[2:0] - 3'd6 : n_bi[2:0];
            if (n_cstage == C_DESEL) res0='{K_XCHG,8'hFF,1'b0,8'h00,1'b0};
            else if (n_cstage == C_FRAME) begin
                unique case (bsel)
                    3'd0: res0='{K_XCHG,n_frame[47:40],1'b1,8'h00,1'b0};
                    3'd1: res0='{K_XCHG,n_frame[39:32],1'b1,8'h00,1'b0};
                    3'd2: res0='{K_XCHG,n_frame[31:24],1'b1,8'h00,1'b0};
                    3'd3: res0='{K_XCHG,n_frame[23:16],1'b1,8'h00,1'b0};
                    3'd4: res0='{K_XCHG,n_frame[15:8],1'b1,8'h00,1'b0};
                    default: res0='{K_XCHG,n_frame[7:0],1'b1,8'h00,1'b0};
                endcase
            end else res0='{K_XCHG,8'hFF,1'b1,8'h00,1'b0};
            cnt=2'd1;
        end
        if (fininit) begin
            n_ctype=finty; n_phase=I_FINAL; ct_out0=finty;
            res0='{K_XCHG,8'hFF,1'b0,8'h00,1'b0}; cnt=2'd1;
        end
        if (fail || bok) begin
            n_phase = fail ? X_FAIL : X_DESEL;
            res0='{K_XCHG,8'hFF,1'b0,8'h00,1'b0}; cnt=2'd1;
        end
        if (fin) begin
            n_phase=P_IDLE; res0='{K_DONE,8'h00,1'b0,8'h00,finst}; cnt=2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase<=P_IDLE; r_ctype<='0; r_cstage<=C_NONE; r_rdy<=0; r_slow<=1;
            r_apppend<=0; r_opw<=0; r_addr<='0; r_left<='0; r_ocr<='0; r_apparg<='0;
            r_bi<='0; r_poll<='0; r_retry<='0; r_frame<='0; r_appidx<='0; r_ptype<='0;
        end else if (acc) begin
            r_phase<=n_phase; r_ctype<=n_ctype; r_cstage<=n_cstage; r_rdy<=n_rdy;
            r_slow<=n_slow; r_apppend<=n_apppend; r_opw<=n_opw; r_addr<=n_addr;
            r_left<=n_left; r_ocr<=n_ocr; r_apparg<=n_apparg; r_bi<=n_bi; r_poll<=n_poll;
            r_retry<=n_retry; r_frame<=n_frame; r_appidx<=n_appidx; r_ptype<=n_ptype;
        end
    end

    logic [24:0] pk0, pk1, ob;
    assign pk0 = {res0.kind, cnt == 2'd1, ct_out0, res0.st, res0.rd, fast0, res0.cs, res0.mosi};
    assign pk1 = {res1.kind, 1'b1, ct_out1, res1.st, res1.rd, fast1, res1.cs, res1.mosi};

    sdsh_out_buf u_buf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(acc), .i_cnt(cnt),
        .i_r0(pk0), .i_r1(pk1), .o_room(room), .o_valid(m_axis_tvalid),
        .o_data(ob), .i_ready(m_axis_tready)
    );
    assign m_axis_tuser = ob[24:23];
    assign m_axis_tlast = ob[22];
    assign m_axis_tdata = {2'b00, ob[21:0]};

    property p_ready_room;
        @(posedge i_clk) disable iff (!i_rst_n) s_axis_tready |-> room;
    endproperty
    a_ready_room: assert property (p_ready_room) else $error("ready without room");
    a_idle_cstage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == P_IDLE |-> r_cstage == C_NONE) else $error("command stage in idle");
    a_bi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == R_DATA |-> r_bi < 10'd512) else $error("byte index overrun");
endmodule
`default_nettype wire
